/* design/pctc_pkg.sv */
// Shared types and constants for the page cache tag controller.
package pctc_pkg;

    // Field widths of the request and response beats.
    localparam int MODE_W  = 3;
    localparam int FILE_W  = 3;
    localparam int PAGE_W  = 16;
    localparam int ENTRY_W = 4;

    // Default sizing of the cache.
    localparam int ENTRIES_DEF = 16;
    localparam int FILES_DEF   = 8;

    // Request modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_READ       = 3'd0,
        MODE_WRITE      = 3'd1,
        MODE_FLUSH_PAGE = 3'd2,
        MODE_FLUSH_ALL  = 3'd3,
        MODE_FLUSH_FILE = 3'd4
    } t_mode;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    // Request beat.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FILE_W-1:0] file_number;
        logic [PAGE_W-1:0] page_id;
        logic              allocate_on_miss;
    } t_req;

    // Response beat.
    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry;
        logic               entry_valid;
        logic               writeback_needed;
        logic [FILE_W-1:0]  writeback_file;
        logic [PAGE_W-1:0]  writeback_page;
        logic               last;
    } t_rsp;

    // Lookup key broadcast to every cell.
    typedef struct packed {
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
        logic              fok;
        logic              flush_all;
    } t_cmd;

    // Update broadcast to every cell; the target index travels beside it.
    typedef struct packed {
        logic              install;
        logic              mark_dirty;
        logic              clr_dirty;
        logic              dirty_val;
        logic [FILE_W-1:0] file;
        logic [PAGE_W-1:0] page;
    } t_upd;

    // Priority link handed from one cell to the next.
    typedef struct packed {
        logic              hit_found;
        logic              hit_dirty;
        logic              free_found;
        logic              cand_found;
        logic              cand_two;
        logic [FILE_W-1:0] cand_file;
        logic [PAGE_W-1:0] cand_page;
        logic              vic_wb;
        logic [FILE_W-1:0] vic_file;
        logic [PAGE_W-1:0] vic_page;
    } t_link;

endpackage

/* design/pctc_chan_if.sv */
// Valid/ready channel carrying one payload beat.
interface pctc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* design/pctc_cell.sv */
// One cache entry: tag storage, local compare and its link in the priority chain.
module pctc_cell #(
    parameter int ENTRIES = pctc_pkg::ENTRIES_DEF,
    parameter int INDEX   = 0,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pctc_pkg::t_cmd  i_cmd,
    input  pctc_pkg::t_upd  i_upd,
    input  logic [IW-1:0]   i_upd_idx,
    input  logic [IW-1:0]   i_vp,
    input  pctc_pkg::t_link i_link,
    input  logic [IW-1:0]   i_hit_idx,
    input  logic [IW-1:0]   i_free_idx,
    input  logic [IW-1:0]   i_cand_idx,
    output pctc_pkg::t_link o_link,
    output logic [IW-1:0]   o_hit_idx,
    output logic [IW-1:0]   o_free_idx,
    output logic [IW-1:0]   o_cand_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic                        r_valid;
    logic                        r_dirty;
    logic [pctc_pkg::FILE_W-1:0] r_file;
    logic [pctc_pkg::PAGE_W-1:0] r_page;

    logic w_match;
    logic w_cand;
    logic w_hit_sel;
    logic w_free_sel;
    logic w_cand_sel;
    logic w_at_vp;
    logic w_at_upd;

    // Local compares.
    assign w_match  = r_valid && i_cmd.fok && (r_file == i_cmd.file) && (r_page == i_cmd.page);
    assign w_cand   = r_valid && r_dirty &&
                      (i_cmd.flush_all || (i_cmd.fok && (r_file == i_cmd.file)));
    assign w_at_vp  = (i_vp == MY_IDX);
    assign w_at_upd = (i_upd_idx == MY_IDX);

    // This cell wins a search only if no lower entry already did.
    assign w_hit_sel  = w_match && !i_link.hit_found;
    assign w_free_sel = !r_valid && !i_link.free_found;
    assign w_cand_sel = w_cand && !i_link.cand_found;

    // Pass the link on to the next cell.
    always_comb begin
        o_link            = i_link;
        o_link.hit_found  = i_link.hit_found || w_match;
        o_link.free_found = i_link.free_found || !r_valid;
        o_link.cand_found = i_link.cand_found || w_cand;
        o_link.cand_two   = i_link.cand_two || (w_cand && i_link.cand_found);
        if (w_hit_sel) begin
            o_link.hit_dirty = r_dirty;
        end
        if (w_cand_sel) begin
            o_link.cand_file = r_file;
            o_link.cand_page = r_page;
        end
        if (w_at_vp) begin
            o_link.vic_wb   = r_valid && r_dirty;
            o_link.vic_file = r_file;
            o_link.vic_page = r_page;
        end
    end

    assign o_hit_idx  = w_hit_sel  ? MY_IDX : i_hit_idx;
    assign o_free_idx = w_free_sel ? MY_IDX : i_free_idx;
    assign o_cand_idx = w_cand_sel ? MY_IDX : i_cand_idx;

    // Valid and dirty bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (w_at_upd) begin
            if (i_upd.install) begin
                r_valid <= 1'b1;
                r_dirty <= i_upd.dirty_val;
            end else if (i_upd.mark_dirty) begin
                r_dirty <= 1'b1;
            end else if (i_upd.clr_dirty) begin
                r_dirty <= 1'b0;
            end
        end
    end

    // Tag storage.
    always_ff @(posedge i_clk) begin
        if (w_at_upd && i_upd.install) begin
            r_file <= i_upd.file;
            r_page <= i_upd.page;
        end
    end

endmodule

/* design/page_cache_tag_controller.sv */
// Top level of the page cache tag controller: sequencer, victim pointer and the cell row.
//
//  Channel   Dir  Payload   Beat
//  i_req     in   t_req     mode, file_number, page_id, allocate_on_miss
//  o_rsp     out  t_rsp     hit, entry, entry_valid, writeback_*, last
//
// Read, write, flush-one-page and unused modes are accepted in ST_IDLE, then
// looked up and updated through the row of entry cells in ST_BUSY. Flush-all
// and flush-file stay in ST_BUSY for one beat per dirty entry reported (at
// least one), since the cell row retires one entry per cycle while the output
// register is free. Reset clears all valid and dirty bits and the victim pointer.
// A response waiting in the output register stalls the lookup cycle only.
module page_cache_tag_controller #(
    parameter int ENTRIES = pctc_pkg::ENTRIES_DEF,
    parameter int FILES   = pctc_pkg::FILES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    pctc_chan_if.sink   i_req,
    pctc_chan_if.source o_rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    pctc_pkg::t_state r_state;
    pctc_pkg::t_state n_state;
    pctc_pkg::t_req   r_req;
    pctc_pkg::t_rsp   r_out;
    pctc_pkg::t_rsp   n_out;
    logic             r_out_valid;
    logic [IW-1:0]    r_vp;
    logic [IW-1:0]    n_vp;

    logic             w_accept;
    logic             w_out_free;
    logic             w_load;
    logic             w_fok;
    pctc_pkg::t_cmd   w_cmd;
    pctc_pkg::t_upd   w_upd;
    logic [IW-1:0]    w_upd_idx;

    pctc_pkg::t_link  w_link     [0:ENTRIES];
    logic [IW-1:0]    w_hit_idx  [0:ENTRIES];
    logic [IW-1:0]    w_free_idx [0:ENTRIES];
    logic [IW-1:0]    w_cand_idx [0:ENTRIES];

    // Handshakes.
    assign i_req.ready = (r_state == pctc_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Command broadcast to the cells.
    assign w_fok          = (32'(r_req.file_number) < FILES);
    assign w_cmd.file     = r_req.file_number;
    assign w_cmd.page     = r_req.page_id;
    assign w_cmd.fok      = w_fok;
    assign w_cmd.flush_all = (r_req.mode == pctc_pkg::MODE_FLUSH_ALL);

    // Cell row; entry 0 has the highest priority.
    assign w_link[0]     = '0;
    assign w_hit_idx[0]  = '0;
    assign w_free_idx[0] = '0;
    assign w_cand_idx[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pctc_cell #(
            .ENTRIES(ENTRIES),
            .INDEX  (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_upd     (w_upd),
            .i_upd_idx (w_upd_idx),
            .i_vp      (r_vp),
            .i_link    (w_link[g]),
            .i_hit_idx (w_hit_idx[g]),
            .i_free_idx(w_free_idx[g]),
            .i_cand_idx(w_cand_idx[g]),
            .o_link    (w_link[g+1]),
            .o_hit_idx (w_hit_idx[g+1]),
            .o_free_idx(w_free_idx[g+1]),
            .o_cand_idx(w_cand_idx[g+1])
        );
    end

    // Sequencer: next state, response beat and cell update.
    always_comb begin
        n_state   = r_state;
        n_out     = '0;
        n_out.last = 1'b1;
        n_vp      = r_vp;
        w_load    = 1'b0;
        w_upd     = '0;
        w_upd_idx = '0;
        w_upd.file = r_req.file_number;
        w_upd.page = r_req.page_id;
        case (r_state)
            pctc_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = pctc_pkg::ST_BUSY;
                end
            end
            pctc_pkg::ST_BUSY: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = pctc_pkg::ST_IDLE;
                    case (r_req.mode)
                        pctc_pkg::MODE_READ, pctc_pkg::MODE_WRITE: begin
                            if (!w_fok) begin
                                // Out-of-range file answers with an empty beat.
                            end else if (w_link[ENTRIES].hit_found) begin
                                n_out.hit         = 1'b1;
                                n_out.entry       = 4'(w_hit_idx[ENTRIES]);
                                n_out.entry_valid = 1'b1;
                                w_upd_idx         = w_hit_idx[ENTRIES];
                                w_upd.mark_dirty  = (r_req.mode == pctc_pkg::MODE_WRITE);
                            end else if ((r_req.mode == pctc_pkg::MODE_READ) &&
                                         !r_req.allocate_on_miss) begin
                                // Read miss without allocation.
                            end else begin
                                w_upd.install   = 1'b1;
                                w_upd.dirty_val = (r_req.mode == pctc_pkg::MODE_WRITE);
                                n_out.entry_valid = 1'b1;
                                if (w_link[ENTRIES].free_found) begin
                                    w_upd_idx   = w_free_idx[ENTRIES];
                                    n_out.entry = 4'(w_free_idx[ENTRIES]);
                                end else begin
                                    // Displace the round-robin victim.
                                    w_upd_idx   = r_vp;
                                    n_out.entry = 4'(r_vp);
                                    n_vp        = (r_vp == LAST_IDX) ? '0 : r_vp + 1'b1;
                                    if (w_link[ENTRIES].vic_wb) begin
                                        n_out.writeback_needed = 1'b1;
                                        n_out.writeback_file   = w_link[ENTRIES].vic_file;
                                        n_out.writeback_page   = w_link[ENTRIES].vic_page;
                                    end
                                end
                            end
                        end
                        pctc_pkg::MODE_FLUSH_PAGE: begin
                            if (w_link[ENTRIES].hit_found) begin
                                n_out.hit         = 1'b1;
                                n_out.entry       = 4'(w_hit_idx[ENTRIES]);
                                n_out.entry_valid = 1'b1;
                                if (w_link[ENTRIES].hit_dirty) begin
                                    w_upd_idx              = w_hit_idx[ENTRIES];
                                    w_upd.clr_dirty        = 1'b1;
                                    n_out.writeback_needed = 1'b1;
                                    n_out.writeback_file   = r_req.file_number;
                                    n_out.writeback_page   = r_req.page_id;
                                end
                            end
                        end
                        pctc_pkg::MODE_FLUSH_ALL, pctc_pkg::MODE_FLUSH_FILE: begin
                            // One dirty entry per beat, lowest first.
                            if (w_link[ENTRIES].cand_found) begin
                                w_upd_idx              = w_cand_idx[ENTRIES];
                                w_upd.clr_dirty        = 1'b1;
                                n_out.hit              = 1'b1;
                                n_out.entry            = 4'(w_cand_idx[ENTRIES]);
                                n_out.entry_valid      = 1'b1;
                                n_out.writeback_needed = 1'b1;
                                n_out.writeback_file   = w_link[ENTRIES].cand_file;
                                n_out.writeback_page   = w_link[ENTRIES].cand_page;
                                n_out.last             = !w_link[ENTRIES].cand_two;
                                if (w_link[ENTRIES].cand_two) begin
                                    n_state = pctc_pkg::ST_BUSY;
                                end
                            end
                        end
                        default: begin
                            // Unused modes answer with an empty beat.
                        end
                    endcase
                end
            end
            default: begin
                n_state = pctc_pkg::ST_IDLE;
            end
        endcase
    end

    // State, victim pointer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pctc_pkg::ST_IDLE;
            r_vp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vp    <= n_vp;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and response payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.data;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // No request is taken in the cycle right after one was accepted.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request accepted while previous one still in lookup");

    // A writeback is always tied to a named entry.
    a_wb_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out.writeback_needed) |-> n_out.entry_valid)
        else $error("writeback reported without an entry");

    // The victim pointer moves only when an install found no free entry.
    a_vp_moves_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_vp != r_vp) |-> (w_upd.install && !w_link[ENTRIES].free_found))
        else $error("victim pointer advanced while a free entry existed");

endmodule
